// ----- hdl/rvx_pkg.sv -----
// Shared types and constants of the RV32I subset execute core.
package rvx_pkg;

   localparam int XLEN      = 32;
   localparam int REG_AW    = 5;
   localparam int REG_DEPTH = 32;
   localparam int REQ_W     = 64;
   localparam int RSP_W     = 144;
   localparam int CSR_AW    = 3;

   localparam logic [CSR_AW-1:0] CSR_DATA_BASE = 3'd0;

   localparam logic ACT_EXEC     = 1'b0;
   localparam logic ACT_LOAD_RET = 1'b1;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_JALR = 3'd0;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [XLEN-1:0] PC_STEP = 32'd4;

   typedef struct packed {
      logic [XLEN-1:0]   pc;
      logic              halt;
      logic              ld_pending;
      logic [REG_AW-1:0] ld_target;
   } core_state_type;

   typedef struct packed {
      logic [XLEN-1:0]   next_pc;
      logic [1:0]        mem_op;
      logic [XLEN-1:0]   mem_addr;
      logic [XLEN-1:0]   mem_wdata;
      logic              reg_written;
      logic [REG_AW-1:0] reg_index;
      logic [XLEN-1:0]   reg_value;
      logic              halted;
   } exec_result_type;

endpackage

// ----- hdl/rv32i_subset_execute_core.sv -----
// Top level of the RV32I subset execute core: handshakes, core state and result register.
//
// Channel  Direction  Handshake              Carries
// req      in         req_tvalid/req_tready  instruction word or load return data
// rsp      out        rsp_tvalid/rsp_tready  next pc, memory access, register write, halt
// csr      in/out     APB psel/penable       data_base register at byte address 0
//
// The register file memory is read at the accepting edge and the item executes in the
// following cycle. The last register write is bypassed around the memory.
// One item is accepted every cycle unless the result stalls.
// Reset clears the pc, halt and load state, the data base and the register valid bits.
// A stalled result holds the execute stage, which in turn holds the input.
module rv32i_subset_execute_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rvx_pkg::REQ_W-1:0]   req_tdata,   // instruction, load_data
   input  logic                        req_tuser,   // action
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // next_pc, mem_op, mem_addr, mem_wdata, reg_written, reg_index, reg_value, halted
   output logic [rvx_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rvx_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [rvx_pkg::XLEN-1:0]    csr_pwdata,
   output logic [rvx_pkg::XLEN-1:0]    csr_prdata,
   output logic                        csr_pready
);
   import rvx_pkg::*;

   logic               s1_valid_ff;
   logic               s1_action_ff;
   logic [XLEN-1:0]    s1_instr_ff;
   logic [XLEN-1:0]    s1_ldata_ff;
   core_state_type     st_ff;
   core_state_type     st_in;
   exec_result_type    res;
   logic [XLEN-1:0]    base_ff;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;
   logic               req_accept;
   logic               s1_advance;
   logic [XLEN-1:0]    rs1_data;
   logic [XLEN-1:0]    rs2_data;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   rvx_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rs1_addr (req_tdata[19:15]),
      .rs2_addr (req_tdata[24:20]),
      .wr_en    (s1_advance && res.reg_written),
      .wr_addr  (res.reg_index),
      .wr_data  (res.reg_value),
      .rs1_data (rs1_data),
      .rs2_data (rs2_data)
   );

   rvx_exec u_exec (
      .action    (s1_action_ff),
      .instr     (s1_instr_ff),
      .load_data (s1_ldata_ff),
      .a         (rs1_data),
      .b         (rs2_data),
      .data_base (base_ff),
      .st        (st_ff),
      .st_in     (st_in),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
         base_ff      <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_DATA_BASE)) begin
            base_ff <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_tuser;
         s1_instr_ff  <= req_tdata[31:0];
         s1_ldata_ff  <= req_tdata[63:32];
      end
      if (s1_advance) begin
         rsp_data_ff <= {7'd0, res.halted, res.reg_value, res.reg_index, res.reg_written,
                         res.mem_wdata, res.mem_addr, res.mem_op, res.next_pc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_prdata = (csr_paddr == CSR_DATA_BASE) ? base_ff : '0;
   assign csr_pready = 1'b1;

endmodule

// ----- hdl/rvx_regfile.sv -----
// Register file memory with one write port, two registered read ports and bypass.
module rvx_regfile (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [rvx_pkg::REG_AW-1:0] rs1_addr,
   input  logic [rvx_pkg::REG_AW-1:0] rs2_addr,
   input  logic                       wr_en,
   input  logic [rvx_pkg::REG_AW-1:0] wr_addr,
   input  logic [rvx_pkg::XLEN-1:0]   wr_data,
   output logic [rvx_pkg::XLEN-1:0]   rs1_data,
   output logic [rvx_pkg::XLEN-1:0]   rs2_data
);
   import rvx_pkg::*;

   logic [XLEN-1:0]      mem [REG_DEPTH];
   logic [XLEN-1:0]      rdata1_ff;
   logic [XLEN-1:0]      rdata2_ff;
   logic [REG_AW-1:0]    raddr1_ff;
   logic [REG_AW-1:0]    raddr2_ff;
   logic [REG_DEPTH-1:0] valid_ff;
   logic                 fwd_valid_ff;
   logic [REG_AW-1:0]    fwd_addr_ff;
   logic [XLEN-1:0]      fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata1_ff <= mem[rs1_addr];
         rdata2_ff <= mem[rs2_addr];
         raddr1_ff <= rs1_addr;
         raddr2_ff <= rs2_addr;
      end
   end

   // The most recent write is kept aside, since a read in the same cycle sees the old word.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
         fwd_valid_ff      <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == raddr1_ff)) begin
         rs1_data = fwd_data_ff;
      end else if (valid_ff[raddr1_ff]) begin
         rs1_data = rdata1_ff;
      end else begin
         rs1_data = '0;
      end
      if (fwd_valid_ff && (fwd_addr_ff == raddr2_ff)) begin
         rs2_data = fwd_data_ff;
      end else if (valid_ff[raddr2_ff]) begin
         rs2_data = rdata2_ff;
      end else begin
         rs2_data = '0;
      end
   end

endmodule

// ----- hdl/rvx_exec.sv -----
// Instruction decode and execute logic producing the result item and next core state.
module rvx_exec (
   input  logic                         action,
   input  logic [rvx_pkg::XLEN-1:0]     instr,
   input  logic [rvx_pkg::XLEN-1:0]     load_data,
   input  logic [rvx_pkg::XLEN-1:0]     a,
   input  logic [rvx_pkg::XLEN-1:0]     b,
   input  logic [rvx_pkg::XLEN-1:0]     data_base,
   input  rvx_pkg::core_state_type      st,
   output rvx_pkg::core_state_type      st_in,
   output rvx_pkg::exec_result_type     res
);
   import rvx_pkg::*;

   logic [6:0]        opcode;
   logic [REG_AW-1:0] rd;
   logic [2:0]        f3;
   logic [6:0]        f7;
   logic [XLEN-1:0]   imm_i;
   logic [XLEN-1:0]   imm_s;
   logic [XLEN-1:0]   imm_b;
   logic [XLEN-1:0]   imm_j;
   logic [XLEN-1:0]   imm_u;
   logic [XLEN-1:0]   pc_plus4;
   logic [XLEN-1:0]   addr_ld;
   logic [XLEN-1:0]   addr_st;
   logic [XLEN-1:0]   jalr_sum;
   logic              lt_ab;
   logic              ltu_ab;
   logic              take;
   logic              wr_req;
   logic [REG_AW-1:0] wr_idx;
   logic [XLEN-1:0]   wr_val;
   logic [XLEN-1:0]   npc;

   assign opcode   = instr[6:0];
   assign rd       = instr[11:7];
   assign f3       = instr[14:12];
   assign f7       = instr[31:25];
   assign imm_i    = {{20{instr[31]}}, instr[31:20]};
   assign imm_s    = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b    = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j    = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign imm_u    = {instr[31:12], 12'h000};
   assign pc_plus4 = st.pc + PC_STEP;
   assign addr_ld  = a + imm_i;
   assign addr_st  = a + imm_s;
   assign jalr_sum = a + imm_i;
   assign lt_ab    = $signed(a) < $signed(b);
   assign ltu_ab   = a < b;

   always_comb begin
      st_in  = st;
      res    = '0;
      wr_req = 1'b0;
      wr_idx = rd;
      wr_val = '0;
      take   = 1'b0;
      npc    = pc_plus4;
      res.next_pc = st.pc;
      res.halted  = st.halt;
      if (action == ACT_LOAD_RET) begin
         if (st.ld_pending) begin
            st_in.ld_pending = 1'b0;
            wr_req = 1'b1;
            wr_idx = st.ld_target;
            wr_val = load_data;
         end
      end else if (st.halt || (instr == '0)) begin
         st_in.halt = 1'b1;
         res.halted = 1'b1;
      end else begin
         unique case (opcode)
            OPC_OP: begin
               if (f7 == F7_BASE) begin
                  wr_req = 1'b1;
                  unique case (f3)
                     F3_ADD:  wr_val = a + b;
                     F3_SLL:  wr_val = a << b[4:0];
                     F3_SLT:  wr_val = {31'd0, lt_ab};
                     F3_SLTU: wr_val = {31'd0, ltu_ab};
                     F3_XOR:  wr_val = a ^ b;
                     F3_SR:   wr_val = a >> b[4:0];
                     F3_OR:   wr_val = a | b;
                     default: wr_val = a & b;
                  endcase
               end else if (f7 == F7_ALT) begin
                  if (f3 == F3_ADD) begin
                     wr_req = 1'b1;
                     wr_val = a - b;
                  end else if (f3 == F3_SR) begin
                     wr_req = 1'b1;
                     wr_val = XLEN'($signed(a) >>> b[4:0]);
                  end
               end
            end
            OPC_OP_IMM: begin
               wr_req = 1'b1;
               unique case (f3)
                  F3_ADD:  wr_val = a + imm_i;
                  F3_SLT:  wr_val = {31'd0, ($signed(a) < $signed(imm_i))};
                  F3_XOR:  wr_val = a ^ imm_i;
                  F3_SR:   wr_val = a >> imm_i[4:0];
                  F3_OR:   wr_val = a | imm_i;
                  F3_AND:  wr_val = a & imm_i;
                  default: wr_req = 1'b0;
               endcase
            end
            OPC_BRANCH: begin
               unique case (f3)
                  F3_BEQ:  take = (a == b);
                  F3_BNE:  take = (a != b);
                  F3_BLT:  take = lt_ab;
                  F3_BGE:  take = !lt_ab;
                  default: take = 1'b0;
               endcase
               if (take) begin
                  npc = st.pc + imm_b;
               end
            end
            OPC_LUI: begin
               wr_req = 1'b1;
               wr_val = imm_u;
            end
            OPC_AUIPC: begin
               wr_req = 1'b1;
               wr_val = st.pc + imm_u;
            end
            OPC_JAL: begin
               wr_req = 1'b1;
               wr_val = pc_plus4;
               npc    = st.pc + imm_j;
            end
            OPC_JALR: begin
               if (f3 == F3_JALR) begin
                  wr_req = 1'b1;
                  wr_val = pc_plus4;
                  npc    = {jalr_sum[XLEN-1:1], 1'b0};
               end
            end
            OPC_LOAD: begin
               if ((f3 == F3_WORD) && !($signed(addr_ld) < $signed(data_base))) begin
                  res.mem_op       = MEM_READ;
                  res.mem_addr     = addr_ld;
                  st_in.ld_pending = 1'b1;
                  st_in.ld_target  = rd;
               end
            end
            OPC_STORE: begin
               if ((f3 == F3_WORD) && !($signed(addr_st) < $signed(data_base))) begin
                  res.mem_op    = MEM_WRITE;
                  res.mem_addr  = addr_st;
                  res.mem_wdata = b;
               end
            end
            default: begin
            end
         endcase
         st_in.pc    = npc;
         res.next_pc = npc;
         res.halted  = 1'b0;
      end
      if (wr_req && (wr_idx != '0)) begin
         res.reg_written = 1'b1;
         res.reg_index   = wr_idx;
         res.reg_value   = wr_val;
      end
   end

endmodule
